FILE: rtl/core/fpp_pkg.sv
// ---------------------------------------------------------------------------
// fpp_pkg
// Shared types, character codes and helpers for the bracketed frame parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpp_pkg;

  // default number of buffered characters per field, the last slot is unused
  localparam int FIELD_BUFFER_DEF = 24;

  localparam int VALUE_W = 16;

  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // frame position
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_F1   = 3'd1,
    PH_F2   = 3'd2,
    PH_F3   = 3'd3,
    PH_F4   = 3'd4
  } phase_t;

  // per-field number scan
  typedef enum logic [1:0] {
    SC_SPACE  = 2'd0,
    SC_SIGN   = 2'd1,
    SC_DIGITS = 2'd2,
    SC_DONE   = 2'd3
  } scan_t;

  // scan state of one field, without its character count
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    scan_t              scan;
    logic               neg;
  } field_t;

  // one finished frame
  typedef struct packed {
    logic [VALUE_W-1:0] value_one;
    logic [VALUE_W-1:0] value_two;
    logic [VALUE_W-1:0] value_three;
    logic [VALUE_W-1:0] value_four;
  } frame_t;

  // status from the frame controller for the item in the input register
  typedef struct packed {
    logic   emit;
    phase_t phase;
  } ctrl_stat_t;

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  // value * 10 + digit, saturated to the field width
  function automatic logic [VALUE_W-1:0] add_digit(input logic [VALUE_W-1:0] v,
                                                   input logic [7:0] ch);
    logic [VALUE_W+3:0] acc;
    logic [7:0]         d;
    d   = ch - CH_ZERO;
    acc = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (VALUE_W+4)'(d[3:0]);
    if (acc[VALUE_W+3:VALUE_W] != 4'b0) begin
      return {VALUE_W{1'b1}};
    end
    return acc[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bracketed_four_value_frame_parser_core.sv
// ---------------------------------------------------------------------------
// bracketed_four_value_frame_parser_core
// Parses [a,b,c,d] character streams into four saturated unsigned values.
// ---------------------------------------------------------------------------
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | in_valid, in_stall, in_rx_byte         | in
//  result   | out_valid, out_stall, out_value_one..  | out
//           | out_value_four                         |
//
//  One character per cycle while in_stall is low: input register, one pass of
//  field logic, then the result register.
//  A closing bracket stalls only while the result register is full and stalled;
//  other characters keep flowing under an output stall.
//  rst_n is synchronous; it clears the frame position and all field state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bracketed_four_value_frame_parser_core #(
  parameter int FIELD_BUFFER = fpp_pkg::FIELD_BUFFER_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fpp_pkg::VALUE_W-1:0]       out_value_one,
  output logic [fpp_pkg::VALUE_W-1:0]       out_value_two,
  output logic [fpp_pkg::VALUE_W-1:0]       out_value_three,
  output logic [fpp_pkg::VALUE_W-1:0]       out_value_four
);
  import fpp_pkg::*;

  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       out_valid_r;
  frame_t     out_frame_r;
  ctrl_stat_t stat;
  frame_t     frame;
  logic       advance;

  // item in the input register moves on unless its result cannot be stored
  assign advance  = hold_valid_r && (!stat.emit || !out_valid_r || !out_stall);
  assign in_stall = hold_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (!in_stall) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_byte_r <= in_rx_byte;
    end
  end

  fpp_frame_ctrl #(
    .FIELD_BUFFER(FIELD_BUFFER)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .step (advance),
    .ch   (hold_byte_r),
    .stat (stat),
    .frame(frame)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && stat.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.emit) begin
      out_frame_r <= frame;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_one   = out_frame_r.value_one;
  assign out_value_two   = out_frame_r.value_two;
  assign out_value_three = out_frame_r.value_three;
  assign out_value_four  = out_frame_r.value_four;

`ifndef SYNTHESIS
  // a frame result lands in the result register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stat.emit |=> out_valid_r)
    else $error("frame result not registered");

  // stall is only raised for a held item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_valid_r |-> !in_stall)
    else $error("stall without held item");

  // an opening bracket always restarts at the first field
  a_open_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (hold_byte_r == CH_OPEN) |=> stat.phase == PH_F1)
    else $error("opening bracket did not restart frame");

  // results only come from a closing bracket in the fourth field
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> (hold_byte_r == CH_CLOSE) && (stat.phase == PH_F4))
    else $error("result from wrong position");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/fpp_field_scan.sv
// ---------------------------------------------------------------------------
// fpp_field_scan
// Next scan state of one field for one received character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpp_field_scan #(
  parameter int FIELD_BUFFER = fpp_pkg::FIELD_BUFFER_DEF,
  parameter int CNT_W        = $clog2(FIELD_BUFFER)
) (
  input  wire logic [7:0]       ch,
  input  wire fpp_pkg::field_t  fld,
  input  wire logic [CNT_W-1:0] cnt,
  output fpp_pkg::field_t       fld_nxt,
  output logic [CNT_W-1:0]      cnt_nxt
);
  import fpp_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(FIELD_BUFFER - 1);

  logic dig;

  assign dig = is_digit(ch);

  // whitespace, sign, digits, then done; characters past the limit are dropped
  always_comb begin
    fld_nxt = fld;
    cnt_nxt = cnt;
    if (cnt < CNT_LIM) begin
      cnt_nxt = cnt + CNT_W'(1);
      case (fld.scan)
        SC_SPACE: begin
          if (is_space(ch)) begin
            fld_nxt.scan = SC_SPACE;
          end else if (ch == CH_PLUS) begin
            fld_nxt.scan = SC_SIGN;
          end else if (ch == CH_MINUS) begin
            fld_nxt.neg  = 1'b1;
            fld_nxt.scan = SC_SIGN;
          end else if (dig) begin
            fld_nxt.value = add_digit(fld.value, ch);
            fld_nxt.scan  = SC_DIGITS;
          end else begin
            fld_nxt.scan = SC_DONE;
          end
        end
        SC_SIGN, SC_DIGITS: begin
          if (dig) begin
            fld_nxt.value = add_digit(fld.value, ch);
            fld_nxt.scan  = SC_DIGITS;
          end else begin
            fld_nxt.scan = SC_DONE;
          end
        end
        default: begin
          fld_nxt.scan = SC_DONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fpp_frame_ctrl.sv
// ---------------------------------------------------------------------------
// fpp_frame_ctrl
// Frame position and the four field registers; updates on each stepped item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpp_frame_ctrl #(
  parameter int FIELD_BUFFER = fpp_pkg::FIELD_BUFFER_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic [7:0]     ch,
  output fpp_pkg::ctrl_stat_t stat,
  output fpp_pkg::frame_t     frame
);
  import fpp_pkg::*;

  localparam int CNT_W = $clog2(FIELD_BUFFER);

  phase_t           phase_r, phase_nxt;
  field_t           fld_r [4];
  logic [CNT_W-1:0] cnt_r [4];
  field_t           fld_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic [1:0]       k;
  logic             in_frame;

  assign in_frame = (phase_r != PH_WAIT);
  assign k        = 2'(phase_r - PH_F1);

  // scan logic shared by the active field
  fpp_field_scan #(
    .FIELD_BUFFER(FIELD_BUFFER),
    .CNT_W       (CNT_W)
  ) u_scan (
    .ch     (ch),
    .fld    (fld_r[k]),
    .cnt    (cnt_r[k]),
    .fld_nxt(fld_upd),
    .cnt_nxt(cnt_upd)
  );

  // next frame position
  always_comb begin
    phase_nxt = phase_r;
    if (ch == CH_OPEN) begin
      phase_nxt = PH_F1;
    end else if (!in_frame) begin
      phase_nxt = PH_WAIT;
    end else if (ch == CH_CLOSE) begin
      phase_nxt = PH_WAIT;
    end else if (ch == CH_COMMA) begin
      case (phase_r)
        PH_F1:   phase_nxt = PH_F2;
        PH_F2:   phase_nxt = PH_F3;
        PH_F3:   phase_nxt = PH_F4;
        PH_F4:   phase_nxt = PH_F4;
        default: phase_nxt = PH_WAIT;
      endcase
    end
  end

  // status and frame outputs
  always_comb begin
    stat.emit  = (ch == CH_CLOSE) && (phase_r == PH_F4);
    stat.phase = phase_r;
    frame.value_one   = fld_r[0].neg ? '0 : fld_r[0].value;
    frame.value_two   = fld_r[1].neg ? '0 : fld_r[1].value;
    frame.value_three = fld_r[2].neg ? '0 : fld_r[2].value;
    frame.value_four  = fld_r[3].neg ? '0 : fld_r[3].value;
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  // field registers: opening bracket clears all, other text updates the active one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        fld_r[i] <= '{value: '0, scan: SC_SPACE, neg: 1'b0};
        cnt_r[i] <= '0;
      end
    end else if (step) begin
      if (ch == CH_OPEN) begin
        for (int i = 0; i < 4; i++) begin
          fld_r[i] <= '{value: '0, scan: SC_SPACE, neg: 1'b0};
          cnt_r[i] <= '0;
        end
      end else if (in_frame && (ch != CH_CLOSE) && (ch != CH_COMMA)) begin
        fld_r[k] <= fld_upd;
        cnt_r[k] <= cnt_upd;
      end
    end
  end

endmodule

`default_nettype wire
